/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/srt_pkg.sv */
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants of the sorted range table.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BYTES  = 8;
    localparam int NAME_BYTES = 8;

    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 64;
    localparam int NAME_W   = 64;
    localparam int SEQ_W    = 7;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int KIND_W   = 2;

    localparam logic [KEY_W-1:0]  KEY_MASK  = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);
    localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} >> (NAME_W - 8 * NAME_BYTES);

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_PAST_END = 3'd1,
        ST_DUP      = 3'd2,
        ST_FULL     = 3'd3,
        ST_ABSENT   = 3'd4
    } t_status;

    // where the result fields come from
    typedef enum logic [1:0] {
        RS_ZERO  = 2'd0,  // status only, entry fields zero
        RS_RDATA = 2'd1,  // entry read at search position
        RS_NEW   = 2'd2,  // freshly inserted entry
        RS_UPD   = 2'd3   // entry whose key was replaced
    } t_res_src;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name;
        logic [SEQ_W-1:0]  seq;
    } t_entry;

    typedef struct packed {
        logic     load;       // take input item, start operation
        logic     rd_mid;     // read midpoint of search window
        logic     step;       // narrow search window on read data
        logic     rd_lo;      // read entry at search position
        logic     sh_init;    // start shift at top of table
        logic     rd_shift;   // read entry below shift index
        logic     wr_shift;   // move entry up one slot
        logic     wr_new;     // write new entry, bump count
        logic     rd_scan;    // read entry at scan index
        logic     scan_next;  // advance scan index
        logic     wr_upd;     // replace key of matched entry
        logic     emit;       // load output register
        t_res_src res_src;
        t_status  status;
    } t_cmd;

    typedef struct packed {
        logic lo_lt_hi;
        logic key_eq;
        logic lo_ge_count;
        logic full;
        logic shift_more;
        logic scan_more;
        logic name_eq;
        logic out_free;
    } t_sts;

endpackage

/* rtl/sorted_range_table.sv */
// ----------------------------------------------------------------------------
// sorted_range_table
// Table of up to 64 entries, inserted in ascending end-key order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: kind, key, name.
//   Kind 0 looks up the first entry at or above key (binary search), kind 1
//   inserts a new entry in sorted place, kind 2 replaces the end key of the
//   first entry whose name matches. Output channel (o_out_valid /
//   i_out_stall) returns exactly one result item per input item (kind 3: past-end status).
//   One item is worked on at a time; o_in_stall is high from acceptance
//   until the result is loaded into the output register.
//   Lookup is a binary search, each step a memory read and a compare;
//   insert searches, then moves every entry above the new position up one
//   slot (a read and then a write each); update scans entries in order,
//   a read and a name compare each. A new item is taken the cycle after
//   the result is loaded. The entry memory does one read and one write per
//   cycle, with registered read data.
//   Reset empties the table (count 0) and drops any pending result; entry
//   storage is not cleared, since only slots below the count are read.
//   While the receiver stalls, the result holds in the output register and
//   the next item may be accepted; it finishes and then waits until the
//   output register frees.
// ----------------------------------------------------------------------------
module sorted_range_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [srt_pkg::KIND_W-1:0]   i_kind,
    input  logic [srt_pkg::KEY_W-1:0]    i_key,
    input  logic [srt_pkg::NAME_W-1:0]   i_name,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [srt_pkg::STATUS_W-1:0] o_status,
    output logic [srt_pkg::SLOT_W-1:0]   o_slot,
    output logic [srt_pkg::KEY_W-1:0]    o_end_key,
    output logic [srt_pkg::NAME_W-1:0]   o_entry_name,
    output logic [srt_pkg::SEQ_W-1:0]    o_seq,
    output logic [srt_pkg::COUNT_W-1:0]  o_count
);

    `include "assert_macros.svh"

    srt_pkg::t_cmd cmd;
    srt_pkg::t_sts sts;
    logic          res_ok;
    logic          res_fail;

    // sequencer: walks each operation through memory accesses
    srt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // memory, search window, indexes and output register
    srt_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (i_key),
        .i_name       (i_name),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_end_key    (o_end_key),
        .o_entry_name (o_entry_name),
        .o_seq        (o_seq),
        .o_count      (o_count)
    );

    assign res_ok   = o_out_valid && (o_status == srt_pkg::ST_OK);
    assign res_fail = o_out_valid &&
                      (o_status inside {srt_pkg::ST_FULL, srt_pkg::ST_ABSENT,
                                        srt_pkg::ST_PAST_END});

    // an accepted item keeps the input side busy next cycle
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // a valid result never reports a count above capacity
    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, o_out_valid, o_count <= 7'd64)
    // a successful result points inside the table
    `ASSERT_IMPL(a_ok_slot, i_clk, i_rst_n, res_ok, o_slot < o_count)
    // failure results carry no entry
    `ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, res_fail, o_slot == '0 && o_seq == '0)

endmodule

/* rtl/srt_ctrl.sv */
// ----------------------------------------------------------------------------
// srt_ctrl
// Operation sequencer: search, shift, scan and result hand-off.
// ----------------------------------------------------------------------------
module srt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_kind,
    output logic            o_in_stall,
    input  srt_pkg::t_sts   i_sts,
    output srt_pkg::t_cmd   o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SRCH_RD  = 9'b000000010,
        S_SRCH_CMP = 9'b000000100,
        S_FETCH    = 9'b000001000,
        S_SH_RD    = 9'b000010000,
        S_SH_WR    = 9'b000100000,
        S_UP_RD    = 9'b001000000,
        S_UP_CMP   = 9'b010000000,
        S_EMIT     = 9'b100000000
    } t_state;

    t_state            r_state,  n_state;
    srt_pkg::t_kind    r_kind,   n_kind;
    srt_pkg::t_status  r_status, n_status;
    srt_pkg::t_res_src r_src,    n_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= srt_pkg::KIND_LOOKUP;
            r_status <= srt_pkg::ST_OK;
            r_src    <= srt_pkg::RS_ZERO;
        end else begin
            r_state  <= n_state;
            r_kind   <= n_kind;
            r_status <= n_status;
            r_src    <= n_src;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_status = r_status;
        n_src    = r_src;
        o_cmd    = '0;
        o_cmd.res_src = r_src;
        o_cmd.status  = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_kind     = srt_pkg::t_kind'(i_kind);
                    case (srt_pkg::t_kind'(i_kind))
                        srt_pkg::KIND_LOOKUP,
                        srt_pkg::KIND_INSERT: n_state = S_SRCH_RD;
                        srt_pkg::KIND_UPDATE: n_state = S_UP_RD;
                        default: begin
                            n_state  = S_EMIT;
                            n_status = srt_pkg::ST_PAST_END;
                            n_src    = srt_pkg::RS_ZERO;
                        end
                    endcase
                end
            end
            S_SRCH_RD: begin
                if (i_sts.lo_lt_hi) begin
                    o_cmd.rd_mid = 1'b1;
                    n_state      = S_SRCH_CMP;
                end else if (r_kind == srt_pkg::KIND_LOOKUP) begin
                    // miss: position is the first larger key, if any
                    if (i_sts.lo_ge_count) begin
                        n_state  = S_EMIT;
                        n_status = srt_pkg::ST_PAST_END;
                        n_src    = srt_pkg::RS_ZERO;
                    end else begin
                        n_state = S_FETCH;
                    end
                end else if (i_sts.full) begin
                    n_state  = S_EMIT;
                    n_status = srt_pkg::ST_FULL;
                    n_src    = srt_pkg::RS_ZERO;
                end else begin
                    o_cmd.sh_init = 1'b1;
                    n_state       = S_SH_RD;
                end
            end
            S_SRCH_CMP: begin
                o_cmd.step = 1'b1;
                if (i_sts.key_eq) begin
                    n_state  = S_EMIT;
                    n_status = (r_kind == srt_pkg::KIND_LOOKUP) ? srt_pkg::ST_OK
                                                                : srt_pkg::ST_DUP;
                    n_src    = srt_pkg::RS_RDATA;
                end else begin
                    n_state = S_SRCH_RD;
                end
            end
            S_FETCH: begin
                o_cmd.rd_lo = 1'b1;
                n_state     = S_EMIT;
                n_status    = srt_pkg::ST_OK;
                n_src       = srt_pkg::RS_RDATA;
            end
            S_SH_RD: begin
                if (i_sts.shift_more) begin
                    o_cmd.rd_shift = 1'b1;
                    n_state        = S_SH_WR;
                end else begin
                    o_cmd.wr_new = 1'b1;
                    n_state      = S_EMIT;
                    n_status     = srt_pkg::ST_OK;
                    n_src        = srt_pkg::RS_NEW;
                end
            end
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                n_state        = S_SH_RD;
            end
            S_UP_RD: begin
                if (i_sts.scan_more) begin
                    o_cmd.rd_scan = 1'b1;
                    n_state       = S_UP_CMP;
                end else begin
                    n_state  = S_EMIT;
                    n_status = srt_pkg::ST_ABSENT;
                    n_src    = srt_pkg::RS_ZERO;
                end
            end
            S_UP_CMP: begin
                if (i_sts.name_eq) begin
                    o_cmd.wr_upd = 1'b1;
                    n_state      = S_EMIT;
                    n_status     = srt_pkg::ST_OK;
                    n_src        = srt_pkg::RS_UPD;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_UP_RD;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/srt_datapath.sv */
// ----------------------------------------------------------------------------
// srt_datapath
// Entry memory, search window, shift/scan index and output register.
// ----------------------------------------------------------------------------
module srt_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [srt_pkg::KEY_W-1:0]    i_key,
    input  logic [srt_pkg::NAME_W-1:0]   i_name,
    input  srt_pkg::t_cmd                i_cmd,
    output srt_pkg::t_sts                o_sts,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [srt_pkg::STATUS_W-1:0] o_status,
    output logic [srt_pkg::SLOT_W-1:0]   o_slot,
    output logic [srt_pkg::KEY_W-1:0]    o_end_key,
    output logic [srt_pkg::NAME_W-1:0]   o_entry_name,
    output logic [srt_pkg::SEQ_W-1:0]    o_seq,
    output logic [srt_pkg::COUNT_W-1:0]  o_count
);

    srt_pkg::t_entry r_mem [srt_pkg::CAPACITY];
    srt_pkg::t_entry r_rdata;

    logic [srt_pkg::CNT_W-1:0]  r_count, r_lo, r_hi, r_idx;
    logic [srt_pkg::IDX_W-1:0]  r_mid;
    logic [srt_pkg::KEY_W-1:0]  r_k;
    logic [srt_pkg::NAME_W-1:0] r_nm;
    logic                       r_out_valid;

    logic [srt_pkg::CNT_W-1:0]  mid_full;
    logic [srt_pkg::CNT_W-1:0]  idx_dn;
    logic                       rd_en, wr_en;
    logic [srt_pkg::IDX_W-1:0]  rd_addr, wr_addr;
    srt_pkg::t_entry            wr_data;

    assign mid_full = r_lo + ((r_hi - r_lo) >> 1);
    assign idx_dn   = r_idx - 1'b1;

    always_comb begin
        rd_en   = i_cmd.rd_mid | i_cmd.rd_lo | i_cmd.rd_shift | i_cmd.rd_scan;
        rd_addr = r_idx[srt_pkg::IDX_W-1:0];
        if (i_cmd.rd_mid) begin
            rd_addr = mid_full[srt_pkg::IDX_W-1:0];
        end else if (i_cmd.rd_lo) begin
            rd_addr = r_lo[srt_pkg::IDX_W-1:0];
        end else if (i_cmd.rd_shift) begin
            rd_addr = idx_dn[srt_pkg::IDX_W-1:0];
        end

        wr_en   = i_cmd.wr_shift | i_cmd.wr_new | i_cmd.wr_upd;
        wr_addr = r_idx[srt_pkg::IDX_W-1:0];
        wr_data = r_rdata;
        if (i_cmd.wr_new) begin
            wr_addr      = r_lo[srt_pkg::IDX_W-1:0];
            wr_data.key  = r_k;
            wr_data.name = r_nm;
            wr_data.seq  = srt_pkg::SEQ_W'(r_count + 1'b1);
        end else if (i_cmd.wr_upd) begin
            wr_data.key = r_k;
        end
    end

    // entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.wr_new) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_k  <= i_key & srt_pkg::KEY_MASK;
            r_nm <= i_name & srt_pkg::NAME_MASK;
            r_lo <= '0;
            r_hi <= r_count;
        end else if (i_cmd.step) begin
            if (o_sts.key_eq) begin
                r_lo <= srt_pkg::CNT_W'(r_mid);
            end else if (r_k < r_rdata.key) begin
                r_hi <= srt_pkg::CNT_W'(r_mid);
            end else begin
                r_lo <= srt_pkg::CNT_W'(r_mid) + 1'b1;
            end
        end
        if (i_cmd.rd_mid) begin
            r_mid <= mid_full[srt_pkg::IDX_W-1:0];
        end
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.sh_init) begin
            r_idx <= r_count;
        end else if (i_cmd.wr_shift) begin
            r_idx <= idx_dn;
        end else if (i_cmd.scan_next) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_comb begin
        o_sts.lo_lt_hi    = (r_lo < r_hi);
        o_sts.key_eq      = (r_k == r_rdata.key);
        o_sts.lo_ge_count = (r_lo >= r_count);
        o_sts.full        = (r_count == srt_pkg::CNT_W'(srt_pkg::CAPACITY));
        o_sts.shift_more  = (r_idx > r_lo);
        o_sts.scan_more   = (r_idx < r_count);
        o_sts.name_eq     = (r_nm == r_rdata.name);
        o_sts.out_free    = !r_out_valid || !i_out_stall;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status <= i_cmd.status;
            o_count  <= srt_pkg::COUNT_W'(r_count);
            case (i_cmd.res_src)
                srt_pkg::RS_RDATA: begin
                    o_slot       <= srt_pkg::SLOT_W'(r_lo);
                    o_end_key    <= r_rdata.key;
                    o_entry_name <= r_rdata.name;
                    o_seq        <= r_rdata.seq;
                end
                srt_pkg::RS_NEW: begin
                    o_slot       <= srt_pkg::SLOT_W'(r_lo);
                    o_end_key    <= r_k;
                    o_entry_name <= r_nm;
                    o_seq        <= srt_pkg::SEQ_W'(r_count);
                end
                srt_pkg::RS_UPD: begin
                    o_slot       <= srt_pkg::SLOT_W'(r_idx);
                    o_end_key    <= r_k;
                    o_entry_name <= r_rdata.name;
                    o_seq        <= r_rdata.seq;
                end
                default: begin
                    o_slot       <= '0;
                    o_end_key    <= '0;
                    o_entry_name <= '0;
                    o_seq        <= '0;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted range table: directed items and random
// bursts of lookup, insert, update and unused-kind items against a behavioral
// table, results compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [srt_pkg::KIND_W-1:0] kind;
        logic [srt_pkg::KEY_W-1:0]  key;
        logic [srt_pkg::NAME_W-1:0] name;
    } t_req;

    typedef struct packed {
        logic [srt_pkg::STATUS_W-1:0] status;
        logic [srt_pkg::SLOT_W-1:0]   slot;
        logic [srt_pkg::KEY_W-1:0]    end_key;
        logic [srt_pkg::NAME_W-1:0]   entry_name;
        logic [srt_pkg::SEQ_W-1:0]    seq;
        logic [srt_pkg::COUNT_W-1:0]  count;
    } t_rsp;

    localparam int WATCHDOG = 20000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [srt_pkg::KIND_W-1:0]   i_kind;
    logic [srt_pkg::KEY_W-1:0]    i_key;
    logic [srt_pkg::NAME_W-1:0]   i_name;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [srt_pkg::STATUS_W-1:0] o_status;
    logic [srt_pkg::SLOT_W-1:0]   o_slot;
    logic [srt_pkg::KEY_W-1:0]    o_end_key;
    logic [srt_pkg::NAME_W-1:0]   o_entry_name;
    logic [srt_pkg::SEQ_W-1:0]    o_seq;
    logic [srt_pkg::COUNT_W-1:0]  o_count;

    sorted_range_table u_top (.*);

    // shadow table
    logic [srt_pkg::KEY_W-1:0]  tbl_key  [srt_pkg::CAPACITY];
    logic [srt_pkg::NAME_W-1:0] tbl_name [srt_pkg::CAPACITY];
    logic [srt_pkg::SEQ_W-1:0]  tbl_seq  [srt_pkg::CAPACITY];
    int                         tbl_cnt = 0;

    t_req pending_items[$];
    t_rsp expected_results[$];
    int   errors = 0;
    bit   wd_expired = 1'b0;
    bit   stim_done;
    int   idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // binary search as the block does it, including on an out-of-order table
    function automatic int find_pos(input logic [srt_pkg::KEY_W-1:0] k, output bit hit);
        int lo;
        int hi;
        int mid;
        lo  = 0;
        hi  = tbl_cnt;
        hit = 1'b0;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (k == tbl_key[mid]) begin
                hit = 1'b1;
                return mid;
            end
            if (k < tbl_key[mid]) hi = mid;
            else lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic t_rsp table_result(input srt_pkg::t_status st, input int pos,
                                          input bit show);
        t_rsp r;
        r = '0;
        r.status = st;
        if (show && pos < tbl_cnt) begin
            r.slot       = pos[srt_pkg::SLOT_W-1:0];
            r.end_key    = tbl_key[pos];
            r.entry_name = tbl_name[pos];
            r.seq        = tbl_seq[pos];
        end
        r.count = tbl_cnt[srt_pkg::COUNT_W-1:0];
        return r;
    endfunction

    function automatic t_rsp apply_item(input t_req q);
        logic [srt_pkg::KEY_W-1:0]  k;
        logic [srt_pkg::NAME_W-1:0] nm;
        bit hit;
        int pos;
        k  = q.key & srt_pkg::KEY_MASK;
        nm = q.name & srt_pkg::NAME_MASK;
        case (srt_pkg::t_kind'(q.kind))
            srt_pkg::KIND_LOOKUP: begin
                pos = find_pos(k, hit);
                if (pos >= tbl_cnt) return table_result(srt_pkg::ST_PAST_END, 0, 0);
                return table_result(srt_pkg::ST_OK, pos, 1);
            end
            srt_pkg::KIND_INSERT: begin
                pos = find_pos(k, hit);
                if (hit) return table_result(srt_pkg::ST_DUP, pos, 1);
                if (tbl_cnt >= srt_pkg::CAPACITY) return table_result(srt_pkg::ST_FULL, 0, 0);
                for (int i = tbl_cnt; i > pos; i--) begin
                    tbl_key[i]  = tbl_key[i-1];
                    tbl_name[i] = tbl_name[i-1];
                    tbl_seq[i]  = tbl_seq[i-1];
                end
                tbl_cnt++;
                tbl_key[pos]  = k;
                tbl_name[pos] = nm;
                tbl_seq[pos]  = tbl_cnt[srt_pkg::SEQ_W-1:0];
                return table_result(srt_pkg::ST_OK, pos, 1);
            end
            srt_pkg::KIND_UPDATE: begin
                for (int i = 0; i < tbl_cnt; i++) begin
                    if (tbl_name[i] == nm) begin
                        tbl_key[i] = k;
                        return table_result(srt_pkg::ST_OK, i, 1);
                    end
                end
                return table_result(srt_pkg::ST_ABSENT, 0, 0);
            end
            default: return table_result(srt_pkg::ST_PAST_END, 0, 0);
        endcase
    endfunction

    // keys mostly from narrow pools so hits, duplicates and name matches are common
    function automatic logic [63:0] pool_val(input int mode);
        case (mode)
            0: return 64'($urandom_range(0, 40));
            1: return {$urandom, $urandom};
            2: return ~64'($urandom_range(0, 3));
            default: return 64'($urandom_range(0, 200)) << $urandom_range(0, 56);
        endcase
    endfunction

    task automatic add_item(input srt_pkg::t_kind kd, input logic [63:0] k,
                            input logic [63:0] nm);
        t_req q;
        q.kind = kd;
        q.key  = k;
        q.name = nm;
        pending_items.push_back(q);
    endtask

    // stimulus
    initial begin
        int n;
        srt_pkg::t_kind kd;
        stim_done = 1'b0;
        // directed: empty table, extremes, duplicates, absent name, unused kind
        add_item(srt_pkg::KIND_LOOKUP, 64'd5, 64'd0);
        add_item(srt_pkg::KIND_UPDATE, 64'd5, 64'd1);
        add_item(srt_pkg::KIND_INSERT, 64'd0, 64'd0);
        add_item(srt_pkg::KIND_INSERT, '1, '1);
        add_item(srt_pkg::KIND_INSERT, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555);
        add_item(srt_pkg::KIND_INSERT, 64'h8000_0000_0000_0000, 64'd9);
        add_item(srt_pkg::KIND_LOOKUP, 64'd0, 64'd0);
        add_item(srt_pkg::KIND_LOOKUP, 64'd1, 64'd0);
        add_item(srt_pkg::KIND_LOOKUP, '1, '1);
        add_item(srt_pkg::KIND_NONE, '1, '1);
        add_item(srt_pkg::KIND_UPDATE, 64'd3, '1);          // breaks sort order
        add_item(srt_pkg::KIND_LOOKUP, 64'd2, 64'd0);
        add_item(srt_pkg::KIND_INSERT, 64'd2, 64'haaaa_aaaa_aaaa_aaaa);
        add_item(srt_pkg::KIND_UPDATE, 64'd7, 64'd77);      // name absent
        add_item(srt_pkg::KIND_UPDATE, 64'd0, 64'h5555_5555_5555_5555); // equal keys
        add_item(srt_pkg::KIND_LOOKUP, 64'd0, 64'd0);
        // fill to capacity, then a full insert and a full-table lookup
        for (int i = 0; i < srt_pkg::CAPACITY; i++)
            add_item(srt_pkg::KIND_INSERT, 64'(100 + 3 * i), 64'(1000 + i));
        add_item(srt_pkg::KIND_INSERT, 64'd50, 64'd1);
        add_item(srt_pkg::KIND_LOOKUP, 64'd150, 64'd0);
        add_item(srt_pkg::KIND_UPDATE, 64'd151, 64'(1000 + srt_pkg::CAPACITY - 1));
        // random: mostly pool keys so the table stays busy
        n = 0;
        while (n < 420) begin
            kd = srt_pkg::t_kind'($urandom_range(0, 99) < 40 ? srt_pkg::KIND_LOOKUP :
                                  $urandom_range(0, 99) < 50 ? srt_pkg::KIND_INSERT :
                                  $urandom_range(0, 9) < 8 ? srt_pkg::KIND_UPDATE :
                                                             srt_pkg::KIND_NONE);
            add_item(kd, pool_val($urandom_range(0, 3)),
                     $urandom_range(0, 3) == 0 ? pool_val(1) : 64'($urandom_range(0, 60)));
            n++;
        end
        stim_done = 1'b1;
    end

    // driver: bursts and gaps
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_kind     <= '0;
            i_key      <= '0;
            i_name     <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(apply_item(pending_items.pop_front()));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_kind     <= pending_items[0].kind;
                    i_key      <= pending_items[0].key;
                    i_name     <= pending_items[0].name;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    int rx_cycle;
    int hold_cnt;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_cycle    <= 0;
            hold_cnt    <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle == 3000) hold_cnt <= 2000;
            else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
            if (rx_cycle >= 3000 && (rx_cycle == 3000 || hold_cnt > 1))
                i_out_stall <= 1'b1;
            else if (rx_cycle[11:9] == 3'd5)
                i_out_stall <= 1'b0;       // stretch without stalls
            else
                i_out_stall <= ($urandom_range(0, 99) < 35);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with none expected: status %0d", o_status);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); errors++;
                end
                if (o_slot !== e.slot) begin
                    $error("slot exp %0d got %0d", e.slot, o_slot); errors++;
                end
                if (o_end_key !== e.end_key) begin
                    $error("end_key exp %h got %h", e.end_key, o_end_key); errors++;
                end
                if (o_entry_name !== e.entry_name) begin
                    $error("entry_name exp %h got %h", e.entry_name, o_entry_name); errors++;
                end
                if (o_seq !== e.seq) begin
                    $error("seq exp %0d got %0d", e.seq, o_seq); errors++;
                end
                if (o_count !== e.count) begin
                    $error("count exp %0d got %0d", e.count, o_count); errors++;
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            begin
                wait (stim_done && pending_items.size() == 0 && !i_in_valid &&
                      expected_results.size() == 0);
                repeat (200) @(posedge i_clk);
            end
            begin
                wait (idle_cycles >= WATCHDOG);
                wd_expired = 1'b1;
                $display("watchdog expired");
            end
        join_any
        if (errors == 0 && !wd_expired && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
